>>> sv/csma_cd_transmit_control_defines.svh
// ----------------------------------------------------------------------------
// CSMA/CD transmit control: assertion macros
// Concurrent assertion helpers, clocked on clk_i; CSMA_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CSMA_CD_TRANSMIT_CONTROL_DEFINES_SVH
`define CSMA_CD_TRANSMIT_CONTROL_DEFINES_SVH

// assertion disabled while in reset
`define CSMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assertion checked during reset as well
`define CSMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/csmatx_pkg.sv
// ----------------------------------------------------------------------------
// CSMA/CD transmit control package
// Types, register codes and reset values shared by the controller files.
// ----------------------------------------------------------------------------
package csmatx_pkg;

  localparam int unsigned GapW   = 10;
  localparam int unsigned JamW   = 8;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned LimW   = 4;
  localparam int unsigned RndW   = 10;
  localparam int unsigned IdleW  = 10;
  localparam int unsigned CountW = 5;
  localparam int unsigned WaitW  = 20;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [GapW-1:0]   GapReset   = 10'd96;
  localparam logic [JamW-1:0]   JamReset   = 8'd32;
  localparam logic [SlotW-1:0]  SlotReset  = 10'd512;
  localparam logic [LimW-1:0]   LimitReset = 4'd10;
  localparam logic [LimW-1:0]   LimitMax   = 4'd10;
  localparam logic [IdleW-1:0]  IdleMax    = 10'd1023;
  localparam logic [CountW-1:0] CountMax   = 5'd31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAP   = 2'd0,
    REG_JAM   = 2'd1,
    REG_SLOT  = 2'd2,
    REG_LIMIT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_SILENCE = 3'd0,
    PH_PACKET  = 3'd1,
    PH_GAP     = 3'd2,
    PH_TX      = 3'd3,
    PH_JAM     = 3'd4,
    PH_BACKOFF = 3'd5
  } phase_e;

  typedef struct packed {
    logic [GapW-1:0]  gap;
    logic [JamW-1:0]  jam;
    logic [SlotW-1:0] slot;
    logic [LimW-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic            busy;
    logic            coll;
    logic            waiting;
    logic            done;
    logic [RndW-1:0] rnd;
  } item_t;

  typedef struct packed {
    logic              transmitting;
    logic              jamming;
    logic              taken;
    logic              released;
    logic [CountW-1:0] collisions;
    logic [2:0]        phase;
  } result_t;

endpackage

>>> sv/csmatx_fsm.sv
// ----------------------------------------------------------------------------
// CSMA/CD transmit control: per-bit-time state machine
// Holds the control state and computes one step and its result per item.
// ----------------------------------------------------------------------------
`include "csma_cd_transmit_control_defines.svh"

module csmatx_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  csmatx_pkg::item_t  item_i,
  input  csmatx_pkg::cfg_t   cfg_i,
  output csmatx_pkg::result_t res_o
);

  csmatx_pkg::phase_e                     phase_q, phase_d;
  logic [csmatx_pkg::IdleW-1:0]           idle_q, idle_d;
  logic [csmatx_pkg::CountW-1:0]          count_q, count_d;
  logic                                   hold_q, hold_d;
  logic [csmatx_pkg::WaitW-1:0]           wait_q, wait_d;

  logic [csmatx_pkg::IdleW-1:0]           idle_inc;
  logic [csmatx_pkg::LimW-1:0]            lim_cap;
  logic [csmatx_pkg::CountW-1:0]          expo;
  logic [csmatx_pkg::RndW:0]              mask_full;
  logic [csmatx_pkg::RndW-1:0]            rnd_masked;
  logic [csmatx_pkg::WaitW-1:0]           backoff;
  logic [csmatx_pkg::WaitW-1:0]           wait_dec;
  logic                                   chk;
  logic [csmatx_pkg::IdleW-1:0]           chk_idle;
  logic                                   took, freed;

  assign idle_inc = (idle_q == csmatx_pkg::IdleMax) ? idle_q : idle_q + 1'b1;

  // truncated binary exponential backoff draw
  assign lim_cap    = (cfg_i.limit > csmatx_pkg::LimitMax) ? csmatx_pkg::LimitMax : cfg_i.limit;
  assign expo       = (count_q > {1'b0, lim_cap}) ? {1'b0, lim_cap} : count_q;
  assign mask_full  = (11'(1) << expo) - 11'(1);
  assign rnd_masked = item_i.rnd & mask_full[csmatx_pkg::RndW-1:0];
  assign backoff    = cfg_i.slot * rnd_masked;
  assign wait_dec   = wait_q - 1'b1;

  always_comb begin
    phase_d  = phase_q;
    idle_d   = idle_q;
    count_d  = count_q;
    hold_d   = hold_q;
    wait_d   = wait_q;
    chk      = 1'b0;
    chk_idle = '0;
    took     = 1'b0;
    freed    = 1'b0;

    unique case (phase_q)
      csmatx_pkg::PH_PACKET: begin
        if (item_i.busy) begin
          phase_d = csmatx_pkg::PH_SILENCE;
        end else begin
          idle_d   = idle_inc;
          chk      = 1'b1;
          chk_idle = idle_inc;
        end
      end
      csmatx_pkg::PH_GAP: begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.gap) phase_d = csmatx_pkg::PH_TX;
      end
      csmatx_pkg::PH_TX: begin
        if (item_i.coll) begin
          if (count_q != csmatx_pkg::CountMax) count_d = count_q + 1'b1;
          wait_d  = csmatx_pkg::WaitW'(cfg_i.jam);
          phase_d = csmatx_pkg::PH_JAM;
        end else if (item_i.done) begin
          hold_d = 1'b0;
          freed  = 1'b1;
          idle_d = '0;
          chk    = 1'b1;
        end
      end
      csmatx_pkg::PH_JAM: begin
        if (wait_q <= csmatx_pkg::WaitW'(1)) begin
          wait_d = backoff;
          if (backoff == '0) begin
            if (item_i.busy) begin
              phase_d = csmatx_pkg::PH_SILENCE;
            end else begin
              idle_d = '0;
              chk    = 1'b1;
            end
          end else begin
            phase_d = csmatx_pkg::PH_BACKOFF;
          end
        end else begin
          wait_d = wait_dec;
        end
      end
      csmatx_pkg::PH_BACKOFF: begin
        if (wait_q <= csmatx_pkg::WaitW'(1)) begin
          wait_d = '0;
          if (item_i.busy) begin
            phase_d = csmatx_pkg::PH_SILENCE;
          end else begin
            idle_d = '0;
            chk    = 1'b1;
          end
        end else begin
          wait_d = wait_dec;
        end
      end
      default: begin
        if (item_i.busy) begin
          phase_d = csmatx_pkg::PH_SILENCE;
        end else begin
          idle_d = '0;
          chk    = 1'b1;
        end
      end
    endcase

    // packet pickup and gap check
    if (chk) begin
      if (!hold_d && !item_i.waiting) begin
        phase_d = csmatx_pkg::PH_PACKET;
      end else begin
        if (!hold_d) begin
          hold_d  = 1'b1;
          count_d = '0;
          took    = 1'b1;
        end
        phase_d = (chk_idle >= cfg_i.gap) ? csmatx_pkg::PH_TX : csmatx_pkg::PH_GAP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= csmatx_pkg::PH_SILENCE;
      idle_q  <= '0;
      count_q <= '0;
      hold_q  <= 1'b0;
      wait_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idle_q  <= idle_d;
      count_q <= count_d;
      hold_q  <= hold_d;
      wait_q  <= wait_d;
    end
  end

  assign res_o.transmitting = (phase_d == csmatx_pkg::PH_TX);
  assign res_o.jamming      = (phase_d == csmatx_pkg::PH_JAM);
  assign res_o.taken        = took;
  assign res_o.released     = freed;
  assign res_o.collisions   = count_d;
  assign res_o.phase        = phase_d;

  `CSMA_ASSERT(a_busy_phase_holds_pkt, (phase_q == csmatx_pkg::PH_GAP || phase_q == csmatx_pkg::PH_TX || phase_q == csmatx_pkg::PH_JAM || phase_q == csmatx_pkg::PH_BACKOFF) |-> hold_q, "active phase without a held packet")
  `CSMA_ASSERT(a_take_sets_hold, (step_i && took) |=> (hold_q && count_q == '0), "packet take did not latch")
  `CSMA_ASSERT(a_jam_fits, (phase_q == csmatx_pkg::PH_JAM) |-> (wait_q <= csmatx_pkg::WaitW'(255)), "jam counter out of range")
  `CSMA_ASSERT(a_no_take_and_hold, (step_i && took) |-> (!hold_q || phase_q == csmatx_pkg::PH_TX), "take while already holding")

endmodule

>>> sv/csma_cd_transmit_control.sv
// ----------------------------------------------------------------------------
// CSMA/CD transmit control
// MAC transmit controller with interframe gap, jam and truncated binary
// exponential backoff; one request per bit time.
// ----------------------------------------------------------------------------
// One request is one bit time of the medium. Each request's result passes
// through the input register and then the result register before it is
// presented, and a request is taken every clock as long as results are
// drained; the state machine step between the two registers sets that rate.
// Registers: 0 gap, 1 jam length, 2 slot time, 3 backoff limit; write them
// only when idle.
module csma_cd_transmit_control (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csmatx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [csmatx_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            carrier_busy_i,
  input  logic                            collision_seen_i,
  input  logic                            packet_waiting_i,
  input  logic                            tx_complete_i,
  input  logic [csmatx_pkg::RndW-1:0]     random_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            transmitting_o,
  output logic                            jamming_o,
  output logic                            packet_taken_o,
  output logic                            packet_released_o,
  output logic [csmatx_pkg::CountW-1:0]   attempt_collisions_o,
  output logic [2:0]                      phase_o
);

  csmatx_pkg::cfg_t    cfg_q;
  csmatx_pkg::item_t   item_q;
  csmatx_pkg::result_t res_d, res_q;
  logic                in_vld_q, out_vld_q;
  logic                advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap   <= csmatx_pkg::GapReset;
      cfg_q.jam   <= csmatx_pkg::JamReset;
      cfg_q.slot  <= csmatx_pkg::SlotReset;
      cfg_q.limit <= csmatx_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (csmatx_pkg::reg_idx_e'(cfg_idx_i))
        csmatx_pkg::REG_GAP:   cfg_q.gap   <= cfg_data_i[csmatx_pkg::GapW-1:0];
        csmatx_pkg::REG_JAM:   cfg_q.jam   <= cfg_data_i[csmatx_pkg::JamW-1:0];
        csmatx_pkg::REG_SLOT:  cfg_q.slot  <= cfg_data_i[csmatx_pkg::SlotW-1:0];
        csmatx_pkg::REG_LIMIT: cfg_q.limit <= cfg_data_i[csmatx_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.busy    <= carrier_busy_i;
      item_q.coll    <= collision_seen_i;
      item_q.waiting <= packet_waiting_i;
      item_q.done    <= tx_complete_i;
      item_q.rnd     <= random_bits_i;
    end
    if (advance) res_q <= res_d;
  end

  csmatx_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_valid_o          = out_vld_q;
  assign transmitting_o       = res_q.transmitting;
  assign jamming_o            = res_q.jamming;
  assign packet_taken_o       = res_q.taken;
  assign packet_released_o    = res_q.released;
  assign attempt_collisions_o = res_q.collisions;
  assign phase_o              = res_q.phase;

endmodule
